### rtl/mapc_pkg.sv
// ----------------------------------------------------------------------------
// mapc_pkg: shared types and constants of the address priority classifier.
// Holds the item layouts, the function and category codes and helpers.
// ----------------------------------------------------------------------------
package mapc_pkg;

  typedef enum logic {
    FUNC_WRITE    = 1'b0,
    FUNC_CLASSIFY = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    CAT_SHM      = 2'd0,
    CAT_LOOPBACK = 2'd1,
    CAT_MATCH    = 2'd2,
    CAT_NONE     = 2'd3
  } cat_e;

  localparam logic [2:0] KIND_TCPV4 = 3'd1;
  localparam logic [2:0] KIND_TCPV6 = 3'd3;
  localparam logic [2:0] KIND_SHM   = 3'd4;
  localparam logic [7:0] BYTE_MAX   = 8'hFF;
  localparam logic [7:0] LOOP_NET   = 8'd127;

  typedef struct packed {
    logic        func;
    logic [3:0]  entry_index;
    logic [2:0]  addr_kind;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [7:0]  prefix_len;
    logic [7:0]  externality;
    logic [7:0]  cost;
    logic        entry_valid;
  } req_t;

  typedef struct packed {
    logic [63:0] ranking;
    logic [1:0]  category;
    logic [3:0]  match_slot;
    logic [7:0]  match_externality;
    logic [7:0]  match_cost;
  } rsp_t;

  // Ranking value built from an externality and a cost.
  function automatic logic [63:0] rank_of(logic [7:0] ext, logic [7:0] cst);
    rank_of = {40'd0, BYTE_MAX - ext, cst, 8'd0};
  endfunction

  // Mask with the top n of 64 bits set; n saturates at 64.
  function automatic logic [63:0] top_mask64(logic [7:0] n);
    logic [63:0] m;
    m = '0;
    if (n >= 8'd64) m = '1;
    else if (n != 8'd0) m = ~(64'hFFFF_FFFF_FFFF_FFFF >> n[5:0]);
    top_mask64 = m;
  endfunction

endpackage

### rtl/mapc_stream_if.sv
// ----------------------------------------------------------------------------
// mapc_stream_if: valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface mapc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/mapc_front.sv
// ----------------------------------------------------------------------------
// mapc_front: input stage with a two-entry queue toward the table engine.
// Takes input transfers while the queue has room.
// ----------------------------------------------------------------------------
module mapc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mapc_pkg::req_t      in_data_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output mapc_pkg::req_t      q_data_o
);
  import mapc_pkg::*;

  req_t       buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_data_o   = buf_q[rd_ptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= in_data_i;
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### rtl/mapc_back.sv
// ----------------------------------------------------------------------------
// mapc_back: table engine. Writes slots and walks them for classify items that
// are not shm or loopback, one slot compare per cycle, with an output register.
// ----------------------------------------------------------------------------
module mapc_back #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           ignore_unmatched_i,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  mapc_pkg::req_t q_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mapc_pkg::rsp_t out_data_o
);
  import mapc_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e      state_q, state_d;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [63:0] mem_hi [TABLE_DEPTH];
  logic [63:0] mem_lo [TABLE_DEPTH];
  logic [2:0]  kind_q [TABLE_DEPTH];
  logic [7:0]  plen_q [TABLE_DEPTH];
  logic [7:0]  ext_q  [TABLE_DEPTH];
  logic [7:0]  cost_q [TABLE_DEPTH];
  logic [63:0] rd_hi_q, rd_lo_q;
  logic        rd_en_q;
  logic [IW-1:0] rd_idx_q, idx_q, wr_idx;
  logic [8:0]  cnt_q;
  req_t        cur_q;
  rsp_t        rsp_q;
  logic        out_valid_q;
  logic        take, loopback, is_v4, hit, wr_ok;
  logic        walk_start, walk_last, walk_next;
  logic [7:0]  n;
  logic [63:0] mh, ml;

  assign q_ready_o   = (state_q == ST_IDLE) && !out_valid_q;
  assign take        = q_valid_i && q_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;
  assign wr_ok       = ({28'd0, q_data_i.entry_index} < 32'(TABLE_DEPTH));
  assign wr_idx      = IW'(q_data_i.entry_index);

  // Walk control: start on a table lookup, stop on a hit or after the last slot.
  assign walk_start = take && (q_data_i.func == FUNC_CLASSIFY) &&
                      (q_data_i.addr_kind != KIND_SHM) && !loopback;
  assign walk_last  = rd_en_q && (cnt_q == 9'(TABLE_DEPTH));
  assign walk_next  = (state_q == ST_WALK) && rd_en_q && !hit && !walk_last;

  // Loopback detection on the incoming item.
  always_comb begin
    loopback = 1'b0;
    if (q_data_i.addr_kind <= KIND_TCPV4)
      loopback = (q_data_i.addr_low[31:24] == LOOP_NET);
    else if (q_data_i.addr_kind <= KIND_TCPV6)
      loopback = (q_data_i.addr_high == 64'd0) && (q_data_i.addr_low == 64'd1);
  end

  // Prefix compare of the current item against the slot read last cycle.
  always_comb begin
    is_v4 = (cur_q.addr_kind <= KIND_TCPV4);
    n     = plen_q[rd_idx_q];
    if (is_v4) begin
      mh = '0;
      ml = top_mask64((n > 8'd32) ? 8'd32 : n) >> 32;
    end else begin
      mh = top_mask64(n);
      ml = top_mask64((n > 8'd64) ? ((n > 8'd128) ? 8'd64 : n - 8'd64) : 8'd0);
    end
    hit = rd_en_q && valid_q[rd_idx_q] && (kind_q[rd_idx_q] == cur_q.addr_kind) &&
          (cur_q.addr_kind <= KIND_SHM) &&
          (((cur_q.addr_high ^ rd_hi_q) & mh) == 64'd0) &&
          (((cur_q.addr_low ^ rd_lo_q) & ml) == 64'd0);
  end

  // Address memories: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (take && q_data_i.func == FUNC_WRITE && wr_ok) begin
      mem_hi[wr_idx] <= q_data_i.addr_high;
      mem_lo[wr_idx] <= q_data_i.addr_low;
      kind_q[wr_idx] <= q_data_i.addr_kind;
      plen_q[wr_idx] <= q_data_i.prefix_len;
      ext_q[wr_idx]  <= q_data_i.externality;
      cost_q[wr_idx] <= q_data_i.cost;
    end
    rd_hi_q  <= mem_hi[idx_q];
    rd_lo_q  <= mem_lo[idx_q];
    rd_idx_q <= idx_q;
  end

  // State transitions.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (walk_start) state_d = ST_WALK;
      ST_WALK: if (hit || walk_last) state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers. The read pointer rests at slot zero between walks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      rd_en_q     <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      rd_en_q <= walk_start || walk_next;
      if (take && q_data_i.func == FUNC_WRITE && wr_ok)
        valid_q[wr_idx] <= q_data_i.entry_valid;
      if (take && !walk_start) out_valid_q <= 1'b1;
      else if (state_q == ST_WALK && (hit || walk_last)) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (walk_start) begin
        idx_q <= IW'(1);
        cnt_q <= 9'd1;
      end else if (walk_next) begin
        idx_q <= idx_q + IW'(1);
        cnt_q <= cnt_q + 9'd1;
      end else if (state_q == ST_WALK) begin
        idx_q <= '0;
      end
    end
  end

  // Current item and result registers.
  always_ff @(posedge clk_i) begin
    if (take) cur_q <= q_data_i;
    if (take && !walk_start) begin
      if (q_data_i.func == FUNC_WRITE) begin
        rsp_q <= '{ranking: 64'd0, category: CAT_NONE, match_slot: 4'd0,
                   match_externality: 8'd0, match_cost: 8'd0};
      end else if (q_data_i.addr_kind == KIND_SHM) begin
        rsp_q <= '{ranking: rank_of(8'd0, 8'd0), category: CAT_SHM, match_slot: 4'd0,
                   match_externality: 8'd0, match_cost: 8'd0};
      end else begin
        rsp_q <= '{ranking: rank_of(8'd0, 8'd1), category: CAT_LOOPBACK,
                   match_slot: 4'd0, match_externality: 8'd0, match_cost: 8'd1};
      end
    end else if (state_q == ST_WALK && hit) begin
      rsp_q <= '{ranking: rank_of(ext_q[rd_idx_q], cost_q[rd_idx_q]),
                 category: CAT_MATCH, match_slot: 4'(rd_idx_q),
                 match_externality: ext_q[rd_idx_q], match_cost: cost_q[rd_idx_q]};
    end else if (state_q == ST_WALK && walk_last) begin
      rsp_q <= '{ranking: ignore_unmatched_i ? '1 : 64'd0, category: CAT_NONE,
                 match_slot: 4'd0, match_externality: 8'd0, match_cost: 8'd0};
    end
  end
endmodule

### rtl/masked_address_priority_classifier.sv
// ----------------------------------------------------------------------------
// masked_address_priority_classifier: prefix match table for locator ranking.
// Writes table slots and ranks remote addresses against them.
// ----------------------------------------------------------------------------
// Write, shared-memory and loopback items pass through the queue register and
// then the result register on their way to the output. A classify that walks
// the table reads one slot per cycle from the address memory, so its result
// waits on the position of the first matching slot. A two-entry queue takes
// new items while the engine walks.
module masked_address_priority_classifier #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  mapc_stream_if.sink   in_if,
  mapc_stream_if.source out_if
);
  import mapc_pkg::*;

  logic ignore_unmatched_q;
  logic q_valid, q_ready;
  req_t q_data;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ignore_unmatched_q <= 1'b0;
    else if (cfg_we_i) ignore_unmatched_q <= cfg_wdata_i;
  end

  mapc_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  mapc_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .ignore_unmatched_i(ignore_unmatched_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(out_if.data)
  );
endmodule

### rtl/mapc_checker.sv
// ----------------------------------------------------------------------------
// mapc_checker: port-level checks of the classifier result stream.
// ----------------------------------------------------------------------------
module mapc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input mapc_pkg::rsp_t out_data_i
);
  import mapc_pkg::*;

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i)) else $error("hold");

  // Shared memory results carry the top externality rank and no attributes.
  a_shm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.category == CAT_SHM |->
    out_data_i.ranking == 64'h0000_0000_00FF_0000 && out_data_i.match_cost == 8'd0)
    else $error("shm");

  // Loopback results carry cost one.
  a_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.category == CAT_LOOPBACK |->
    out_data_i.match_cost == 8'd1 && out_data_i.ranking == 64'h0000_0000_00FF_0100)
    else $error("loop");

  // Unmatched results carry no slot attributes.
  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.category == CAT_NONE |->
    out_data_i.match_slot == 4'd0 && out_data_i.match_externality == 8'd0)
    else $error("none");
endmodule

bind masked_address_priority_classifier mapc_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready), .out_data_i(out_if.data)
);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for masked_address_priority_classifier.
// Drives table writes and classify lookups through the input channel, predicts
// each ranking result from a shadow copy of the table and the register, and
// compares every result transfer field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mapc_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [2:0] KIND_UDPV4 = 3'd0;
  localparam logic [2:0] KIND_TCPV4_L = 3'd1;
  localparam logic [2:0] KIND_UDPV6 = 3'd2;
  localparam logic [2:0] KIND_TCPV6_L = 3'd3;
  localparam logic [2:0] KIND_SHM_L = 3'd4;
  localparam logic [2:0] KIND_BAD = 3'd7;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int RANDOM_ITEMS = 750;
  localparam int DRAIN_CYCLES = 3 * DEPTH + 20;
  localparam int STALL_CYCLES = 200;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  mapc_stream_if #(.T(req_t)) req_if ();
  mapc_stream_if #(.T(rsp_t)) rsp_if ();

  masked_address_priority_classifier #(.TABLE_DEPTH(DEPTH)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (req_if.sink),
    .out_if      (rsp_if.source)
  );

  // Shadow table and register used for ranking prediction.
  logic [63:0] shadow_high [DEPTH];
  logic [63:0] shadow_low [DEPTH];
  logic        shadow_valid [DEPTH];
  logic [2:0]  shadow_kind [DEPTH];
  logic [7:0]  shadow_prefix [DEPTH];
  logic [7:0]  shadow_ext [DEPTH];
  logic [7:0]  shadow_cost [DEPTH];
  logic        unmatched_all_ones;

  rsp_t pending_ranks[$];
  int   error_count;
  bit   hold_off;

  // Clock and reset.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Appends one expected result at the tail of the queue.
  task automatic expect_result(rsp_t p);
    pending_ranks = {pending_ranks, p};
  endtask

  // Top bits of a w-bit field compared for a prefix of n bits.
  function automatic logic [63:0] lead_mask(int n, int w);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < w; b++) begin
      if (b < n) m[w - 1 - b] = 1'b1;
    end
    return m;
  endfunction

  // Works out the result of one item and updates the shadow table.
  function automatic rsp_t rank_predict(req_t r);
    rsp_t p;
    bit hit;
    int n;
    bit pm;
    p = '{ranking: '0, category: CAT_NONE, match_slot: '0,
          match_externality: '0, match_cost: '0};
    if (r.func == FUNC_WRITE) begin
      shadow_high[r.entry_index] = r.addr_high;
      shadow_low[r.entry_index] = r.addr_low;
      shadow_valid[r.entry_index] = r.entry_valid;
      shadow_kind[r.entry_index] = r.addr_kind;
      shadow_prefix[r.entry_index] = r.prefix_len;
      shadow_ext[r.entry_index] = r.externality;
      shadow_cost[r.entry_index] = r.cost;
    end else if (r.addr_kind == KIND_SHM_L) begin
      p.ranking = {40'd0, 8'hFF, 16'd0};
      p.category = CAT_SHM;
    end else if ((r.addr_kind <= KIND_TCPV4_L && r.addr_low[31:24] == 8'd127) ||
                 (r.addr_kind inside {KIND_UDPV6, KIND_TCPV6_L} &&
                  r.addr_high == '0 && r.addr_low == 64'd1)) begin
      p.ranking = {40'd0, 8'hFF, 8'd1, 8'd0};
      p.category = CAT_LOOPBACK;
      p.match_cost = 8'd1;
    end else begin
      hit = 1'b0;
      for (int i = 0; i < DEPTH && !hit; i++) begin
        if (!shadow_valid[i] || shadow_kind[i] != r.addr_kind) continue;
        pm = 1'b0;
        if (r.addr_kind <= KIND_TCPV4_L) begin
          n = shadow_prefix[i] > 32 ? 32 : shadow_prefix[i];
          pm = ((r.addr_low ^ shadow_low[i]) & lead_mask(n, 32)) == '0;
        end else if (r.addr_kind <= KIND_SHM_L) begin
          n = shadow_prefix[i] > 128 ? 128 : shadow_prefix[i];
          pm = ((r.addr_high ^ shadow_high[i]) & lead_mask(n > 64 ? 64 : n, 64)) == '0
            && ((r.addr_low ^ shadow_low[i]) & lead_mask(n > 64 ? n - 64 : 0, 64)) == '0;
        end
        if (pm) begin
          hit = 1'b1;
          p.category = CAT_MATCH;
          p.match_slot = i[3:0];
          p.match_externality = shadow_ext[i];
          p.match_cost = shadow_cost[i];
          p.ranking = {40'd0, 8'hFF - shadow_ext[i], shadow_cost[i], 8'd0};
        end
      end
      if (!hit) p.ranking = unmatched_all_ones ? ALL_ONES : '0;
    end
    return p;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    error_count++;
  endtask

  // Result checker: compares each transfer with the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t got;
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (pending_ranks.size() == 0) begin
        report("unexpected result ranking", got.ranking, '0);
      end else begin
        want = pending_ranks.pop_front();
        if (got.ranking !== want.ranking) report("ranking", got.ranking, want.ranking);
        if (got.category !== want.category) report("category", got.category, want.category);
        if (got.match_slot !== want.match_slot)
          report("match_slot", got.match_slot, want.match_slot);
        if (got.match_externality !== want.match_externality)
          report("match_externality", got.match_externality, want.match_externality);
        if (got.match_cost !== want.match_cost)
          report("match_cost", got.match_cost, want.match_cost);
      end
    end
  end

  // Receiver stall pattern; a long hold-off is counted here when requested.
  initial begin
    int mode;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        rsp_if.ready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk_i);
        hold_off = 1'b0;
      end
      mode = ($time / 4000) % 3;
      if (mode == 0) rsp_if.ready <= 1'b1;
      else if (mode == 1) rsp_if.ready <= ($urandom_range(0, 3) != 0);
      else rsp_if.ready <= ($urandom_range(0, 2) == 0);
    end
  end

  // Sends one item: waits for the transfer, then leaves valid to the caller.
  task automatic send_item(req_t r);
    req_if.data <= r;
    req_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    expect_result(rank_predict(r));
    @(negedge clk_i);
  endtask

  // Sender gap between bursts.
  task automatic burst_gap(ref int left);
    if (left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      left = $urandom_range(1, 20);
    end
    left--;
  endtask

  task automatic drain_and_config(logic value);
    req_if.valid <= 1'b0;
    while (pending_ranks.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    unmatched_all_ones = value;
  endtask

  function automatic req_t make_item(logic f, logic [3:0] idx, logic [2:0] k,
                                     logic [63:0] h, logic [63:0] l, logic [7:0] pl,
                                     logic [7:0] e, logic [7:0] c, logic v);
    return '{func: f, entry_index: idx, addr_kind: k, addr_high: h, addr_low: l,
             prefix_len: pl, externality: e, cost: c, entry_valid: v};
  endfunction

  // Random address that shares a prefix with slot s, or is fully random.
  function automatic req_t random_item(int phase_kind_bias);
    req_t r;
    int s;
    r = make_item($urandom_range(0, 2) != 0, $urandom(), $urandom_range(0, 4),
                  {$urandom(), $urandom()}, {$urandom(), $urandom()},
                  $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 130),
                  $urandom(), $urandom(), $urandom_range(0, 4) != 0);
    if ($urandom_range(0, 19) == 0) r.addr_kind = $urandom_range(5, 7);
    if (r.func == FUNC_CLASSIFY) begin
      s = $urandom_range(0, DEPTH - 1);
      if ($urandom_range(0, 3) != 0 && shadow_valid[s]) begin
        // Near match: reuse the slot address; at random flip a low or high bit.
        r.addr_kind = shadow_kind[s];
        r.addr_high = shadow_high[s];
        r.addr_low = shadow_low[s];
        if ($urandom_range(0, 1)) r.addr_low[$urandom_range(0, 63)] ^= 1'b1;
        if ($urandom_range(0, 3) == 0) r.addr_high[$urandom_range(0, 63)] ^= 1'b1;
      end else if ($urandom_range(0, 15) == 0) begin
        r.addr_low[31:24] = 8'd127;
      end
    end else if (phase_kind_bias != 0) begin
      r.prefix_len = $urandom_range(0, 40);
    end
    return r;
  endfunction

  // Stimulus.
  initial begin
    typedef struct {
      req_t r;
      bit   typed;
      rsp_t want;
    } row_t;
    row_t rows[$];
    rsp_t w_none;
    rsp_t got_pred;
    int left;
    req_t r;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    error_count = 0;
    hold_off = 1'b0;
    unmatched_all_ones = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_high[i] = '0;
      shadow_low[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_kind[i] = '0;
      shadow_prefix[i] = '0;
      shadow_ext[i] = '0;
      shadow_cost[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    w_none = '{ranking: '0, category: CAT_NONE, match_slot: '0,
               match_externality: '0, match_cost: '0};
    // Directed table: extremes, every kind, loopback, prefix corners.
    rows = '{
      '{make_item(FUNC_CLASSIFY, 0, KIND_UDPV4, '0, 64'h0A000001, 0, 0, 0, 0), 1, w_none},
      '{make_item(FUNC_CLASSIFY, 0, KIND_SHM_L, ALL_ONES, ALL_ONES, 0, 0, 0, 0), 1,
        '{64'hFF0000, CAT_SHM, 4'd0, 8'd0, 8'd0}},
      '{make_item(FUNC_CLASSIFY, 0, KIND_TCPV4_L, '0, 64'h7F000001, 0, 0, 0, 0), 1,
        '{64'hFF0100, CAT_LOOPBACK, 4'd0, 8'd0, 8'd1}},
      '{make_item(FUNC_CLASSIFY, 0, KIND_UDPV6, '0, 64'd1, 0, 0, 0, 0), 1,
        '{64'hFF0100, CAT_LOOPBACK, 4'd0, 8'd0, 8'd1}},
      '{make_item(FUNC_WRITE, 15, KIND_UDPV4, ALL_ONES, 64'hC0A80100, 24, 255, 255, 1), 1,
        w_none},
      '{make_item(FUNC_CLASSIFY, 0, KIND_UDPV4, '0, 64'hC0A801FE, 0, 0, 0, 0), 1,
        '{64'h00FF00, CAT_MATCH, 4'd15, 8'd255, 8'd255}},
      '{make_item(FUNC_WRITE, 0, KIND_TCPV6_L, ALL_ONES, ALL_ONES, 255, 0, 0, 1), 0, w_none},
      '{make_item(FUNC_CLASSIFY, 0, KIND_TCPV6_L, ALL_ONES, ALL_ONES, 0, 0, 0, 0), 0, w_none},
      '{make_item(FUNC_CLASSIFY, 0, KIND_TCPV6_L, ALL_ONES, 64'hFFFFFFFFFFFFFFFE, 0, 0, 0, 0),
        0, w_none},
      '{make_item(FUNC_WRITE, 1, KIND_UDPV6, '0, '0, 0, 7, 9, 1), 0, w_none},
      '{make_item(FUNC_CLASSIFY, 0, KIND_UDPV6, 64'h2001, 64'h5, 0, 0, 0, 0), 0, w_none},
      '{make_item(FUNC_WRITE, 2, KIND_TCPV4_L, '0, 64'h0A000000, 200, 3, 4, 1), 0, w_none},
      '{make_item(FUNC_CLASSIFY, 0, KIND_TCPV4_L, ALL_ONES, 64'h0A000000, 0, 0, 0, 0), 0,
        w_none},
      '{make_item(FUNC_WRITE, 3, KIND_SHM_L, 64'h1, 64'h2, 65, 1, 2, 1), 0, w_none},
      '{make_item(FUNC_CLASSIFY, 0, KIND_BAD, '0, 64'h7F000001, 0, 0, 0, 0), 1, w_none},
      '{make_item(FUNC_WRITE, 2, KIND_TCPV4_L, '0, '0, 0, 0, 0, 0), 0, w_none},
      '{make_item(FUNC_CLASSIFY, 0, KIND_TCPV4_L, '0, 64'h0A000000, 0, 0, 0, 0), 1, w_none}
    };
    foreach (rows[i]) begin
      req_if.data <= rows[i].r;
      req_if.valid <= 1'b1;
      @(posedge clk_i);
      while (!req_if.ready) @(posedge clk_i);
      got_pred = rank_predict(rows[i].r);
      if (rows[i].typed && got_pred !== rows[i].want)
        report("directed row prediction", i, 0);
      expect_result(rows[i].typed ? rows[i].want : got_pred);
      @(negedge clk_i);
    end

    // Register at one: unmatched lookups give all ones.
    drain_and_config(1'b1);
    send_item(make_item(FUNC_CLASSIFY, 0, KIND_BAD, '0, '0, 0, 0, 0, 0));

    // Random phases, alternating the register; one long receiver hold-off.
    left = 0;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 1) hold_off = 1'b1;
      for (int k = 0; k < RANDOM_ITEMS / 4; k++) begin
        burst_gap(left);
        r = random_item(ph % 2);
        send_item(r);
      end
      drain_and_config(ph % 2);
    end

    req_if.valid <= 1'b0;
    while (pending_ranks.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule
